/* hw/rtl/fifo_with_min_max_defines.svh */
// ----------------------------------------------------------------------------
// FIFO with min/max query: assertion macros
// Shared property shapes for the checker. Every property is clocked on clk
// and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_MIN_MAX_DEFINES_SVH
`define FIFO_WITH_MIN_MAX_DEFINES_SVH

// The condition holds in the same cycle as the trigger.
`define FWMM_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("fifo_with_min_max check failed");

// The condition holds in the cycle after the trigger.
`define FWMM_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("fifo_with_min_max check failed");

`endif

/* hw/rtl/fwmm_pkg.sv */
// ----------------------------------------------------------------------------
// FIFO with min/max query: package
// Types and fixed constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fwmm_pkg;

  // Field widths fixed by the stream format.
  localparam int VAL_W = 32;
  localparam int CNT_OUT_W = 6;

  // Extremes used to seed the scan.
  localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  // Request kinds carried in the input tuser.
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;     // Carry out the accepted request.
    logic scan_rd;  // Issue one scan read of the store.
    logic load;     // Move the finished result into the output register.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic none_left;  // No value held after the request being executed.
    logic scan_last;  // The current scan read is the final one.
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/fifo_with_min_max.sv */
// A bounded FIFO of signed 32-bit values that reports, with every request,
// the value removed, a status, the entry count and the largest and smallest
// values still held. Each request produces exactly one result. After a
// request is accepted, the min/max scan reads one stored entry per cycle
// through the single read port of the value store, one entry for each value
// held after the request; a wait state then takes the last read return and
// the done state loads the result into the output register. The controller
// is ready again in the cycle after the load, so a new request is accepted
// only once the result of the last one has been loaded.
// One request is in flight at a time; a finished result waits in the output
// register without blocking the next request's scan, but the next result is
// not loaded until the output register is free. The store needs no clearing
// after reset.
// ----------------------------------------------------------------------------
// FIFO with min/max query: top level
// Stream interface around the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_min_max #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // push_value[31:0]
  input  wire logic         s_axis_tuser,   // req_type[0]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [103:0] m_axis_tdata,   // popped_value[31:0], entry_count[37:32],
                                            // largest_value[69:38],
                                            // smallest_value[101:70], zero[103:102]
  output logic      [1:0]   m_axis_tuser    // status[1:0]
);

  fwmm_pkg::cmd_t cmd;
  fwmm_pkg::sts_t sts;
  fwmm_pkg::status_t status;
  logic signed [fwmm_pkg::VAL_W-1:0] popped_value;
  logic signed [fwmm_pkg::VAL_W-1:0] largest_value;
  logic signed [fwmm_pkg::VAL_W-1:0] smallest_value;
  logic [fwmm_pkg::CNT_OUT_W-1:0] entry_count;

  fwmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  fwmm_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_type       (s_axis_tuser),
    .push_value     ($signed(s_axis_tdata)),
    .popped_value   (popped_value),
    .status         (status),
    .entry_count    (entry_count),
    .largest_value  (largest_value),
    .smallest_value (smallest_value)
  );

  // Result packing, first field in the lowest bits.
  assign m_axis_tdata = {2'b00, smallest_value, largest_value, entry_count, popped_value};
  assign m_axis_tuser = status;

endmodule

`default_nettype wire

/* hw/rtl/fwmm_ram.sv */
// ----------------------------------------------------------------------------
// FIFO with min/max query: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fwmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fwmm_datapath.sv */
// ----------------------------------------------------------------------------
// FIFO with min/max query: datapath
// Ring pointers, the value store, the min/max scan and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fwmm_datapath #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire fwmm_pkg::cmd_t                    cmd,
  output fwmm_pkg::sts_t                         sts,
  input  wire logic                              req_type,
  input  wire logic signed [fwmm_pkg::VAL_W-1:0] push_value,
  output logic signed [fwmm_pkg::VAL_W-1:0]      popped_value,
  output fwmm_pkg::status_t                      status,
  output logic [fwmm_pkg::CNT_OUT_W-1:0]         entry_count,
  output logic signed [fwmm_pkg::VAL_W-1:0]      largest_value,
  output logic signed [fwmm_pkg::VAL_W-1:0]      smallest_value
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail;
  logic [CW-1:0] cnt, cnt_next;
  logic [AW-1:0] scan_ptr;
  logic [CW-1:0] scan_left;
  logic pop_pend;
  logic fold_pend;
  fwmm_pkg::status_t stat_q;
  logic signed [fwmm_pkg::VAL_W-1:0] popped_q;
  logic signed [fwmm_pkg::VAL_W-1:0] max_q;
  logic signed [fwmm_pkg::VAL_W-1:0] min_q;
  logic signed [fwmm_pkg::VAL_W-1:0] rd_val;
  logic [fwmm_pkg::VAL_W-1:0] rd_data;
  logic [CW+fwmm_pkg::CNT_OUT_W-1:0] cnt_ext;
  logic is_full, is_empty, do_push, do_pop;
  logic mem_re;
  logic [AW-1:0] mem_raddr;

  // Decode the request being executed.
  assign is_full  = (cnt == FULL_CNT);
  assign is_empty = (cnt == '0);
  assign do_push  = cmd.exec && (req_type == fwmm_pkg::REQ_ENQ) && !is_full;
  assign do_pop   = cmd.exec && (req_type == fwmm_pkg::REQ_DEQ) && !is_empty;

  // Pointer and count updates of the request.
  always_comb begin
    head_next = head;
    cnt_next  = cnt;
    if (do_pop) begin
      head_next = (head == LAST_SLOT) ? '0 : head + 1'b1;
      cnt_next  = cnt - 1'b1;
    end else if (do_push) begin
      cnt_next = cnt + 1'b1;
    end
  end

  assign sts.none_left = (cnt_next == '0);
  assign sts.scan_last = (scan_left == CW'(1));

  // The single read port serves the dequeue first, then the scan.
  assign mem_re    = do_pop || cmd.scan_rd;
  assign mem_raddr = cmd.exec ? head : scan_ptr;

  fwmm_ram #(
    .WIDTH (fwmm_pkg::VAL_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (tail),
    .wdata (push_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  assign rd_val = $signed(rd_data);

  // Ring pointers, count and read-return flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      cnt       <= '0;
      pop_pend  <= 1'b0;
      fold_pend <= 1'b0;
    end else begin
      head      <= head_next;
      cnt       <= cnt_next;
      pop_pend  <= do_pop;
      fold_pend <= cmd.scan_rd;
      if (do_push) begin
        tail <= (tail == LAST_SLOT) ? '0 : tail + 1'b1;
      end
    end
  end

  // Request result and the running min/max over the scanned entries.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      scan_ptr  <= head_next;
      scan_left <= cnt_next;
      popped_q  <= '0;
      max_q     <= fwmm_pkg::INT_MIN;
      min_q     <= fwmm_pkg::INT_MAX;
      if (req_type == fwmm_pkg::REQ_ENQ) begin
        stat_q <= is_full ? fwmm_pkg::STAT_FULL : fwmm_pkg::STAT_OK;
      end else begin
        stat_q <= is_empty ? fwmm_pkg::STAT_EMPTY : fwmm_pkg::STAT_OK;
      end
    end else begin
      if (cmd.scan_rd) begin
        scan_ptr  <= (scan_ptr == LAST_SLOT) ? '0 : scan_ptr + 1'b1;
        scan_left <= scan_left - 1'b1;
      end
      if (pop_pend) begin
        popped_q <= rd_val;
      end
      if (fold_pend) begin
        if (rd_val > max_q) begin
          max_q <= rd_val;
        end
        if (rd_val < min_q) begin
          min_q <= rd_val;
        end
      end
    end
  end

  assign cnt_ext = (CW + fwmm_pkg::CNT_OUT_W)'(cnt);

  // Output register; an empty queue reports zero extremes.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      popped_value   <= popped_q;
      status         <= stat_q;
      entry_count    <= cnt_ext[fwmm_pkg::CNT_OUT_W-1:0];
      largest_value  <= is_empty ? '0 : max_q;
      smallest_value <= is_empty ? '0 : min_q;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fwmm_ctrl.sv */
// ----------------------------------------------------------------------------
// FIFO with min/max query: controller
// Sequences one request through execute, scan and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fwmm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output fwmm_pkg::cmd_t      cmd,
  input  wire fwmm_pkg::sts_t sts
);

  fwmm_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      fwmm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = sts.none_left ? fwmm_pkg::S_WAIT : fwmm_pkg::S_SCAN;
        end
      end
      fwmm_pkg::S_SCAN: begin
        if (sts.scan_last) begin
          state_next = fwmm_pkg::S_WAIT;
        end
      end
      fwmm_pkg::S_WAIT: begin
        state_next = fwmm_pkg::S_DONE;
      end
      fwmm_pkg::S_DONE: begin
        if (out_free) begin
          state_next = fwmm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fwmm_pkg::S_IDLE;
      end
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    in_ready    = 1'b0;
    cmd.exec    = 1'b0;
    cmd.scan_rd = 1'b0;
    cmd.load    = 1'b0;
    case (state)
      fwmm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
      end
      fwmm_pkg::S_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      fwmm_pkg::S_DONE: begin
        cmd.load = out_free;
      end
      default: begin
      end
    endcase
  end

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fwmm_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fwmm_checker.sv */
// ----------------------------------------------------------------------------
// FIFO with min/max query: port checker
// Watches the result stream of the top level and checks its consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fifo_with_min_max_defines.svh"

module fwmm_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [103:0] m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser
);

  logic signed [31:0] popped;
  logic signed [31:0] largest;
  logic signed [31:0] smallest;
  logic [5:0] count;
  logic stalled;
  logic empty_status;

  // Unpack the result fields.
  assign popped       = $signed(m_axis_tdata[31:0]);
  assign count        = m_axis_tdata[37:32];
  assign largest      = $signed(m_axis_tdata[69:38]);
  assign smallest     = $signed(m_axis_tdata[101:70]);
  assign stalled      = m_axis_tvalid && !m_axis_tready;
  assign empty_status = (m_axis_tuser == fwmm_pkg::STAT_EMPTY);

  // A stalled result stays put.
  `FWMM_ASSERT_NEXT(a_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata))

  // An empty queue reports zero extremes.
  `FWMM_ASSERT_SAME(a_empty_zero, m_axis_tvalid && (count == 6'd0),
                    (largest == 32'sd0) && (smallest == 32'sd0))

  // The smallest held value never exceeds the largest.
  `FWMM_ASSERT_SAME(a_order, m_axis_tvalid && (count != 6'd0), smallest <= largest)

  // A dequeue on an empty queue removes nothing and leaves it empty.
  `FWMM_ASSERT_SAME(a_deq_empty, m_axis_tvalid && empty_status,
                    (count == 6'd0) && (popped == 32'sd0))

endmodule

bind fifo_with_min_max fwmm_checker u_fwmm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* test/fifo_minmax_checker.sv */
// ----------------------------------------------------------------------------
// FIFO with min/max query: result checker
// Watches both stream channels and keeps its own copy of the queue. Every
// accepted request updates that copy and yields the expected result.
// Every accepted result is compared field by field with the oldest
// outstanding expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_minmax_checker #(
  parameter int RING_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // push_value[31:0]
  input  logic         s_axis_tuser,   // req_type[0]
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,   // popped_value[31:0], entry_count[37:32],
                                       // largest_value[69:38],
                                       // smallest_value[101:70], zero[103:102]
  input  logic [1:0]   m_axis_tuser,   // status[1:0]
  output int           mismatch_count,
  output int           results_owed
);

  typedef struct {
    logic [31:0]       popped;
    fwmm_pkg::status_t status;
    logic [5:0]        count;
    logic [31:0]       largest;
    logic [31:0]       lowest;
  } queue_report_t;

  // Shadow copy of the queue contents.
  logic signed [31:0] shadow_ring [RING_DEPTH];
  int unsigned        ring_head;
  int unsigned        ring_tail;
  int unsigned        ring_fill;

  // Results owed by the block, oldest first.
  queue_report_t owed_reports [$];

  // Carry out one request on the shadow queue and report what it should give.
  function automatic queue_report_t apply_request(input logic kind,
                                                  input logic [31:0] value);
    queue_report_t      r;
    logic signed [31:0] highest;
    logic signed [31:0] least;
    int unsigned        slot;
    r.popped = '0;
    r.status = fwmm_pkg::STAT_OK;
    if (kind == fwmm_pkg::REQ_ENQ) begin
      if (ring_fill >= RING_DEPTH) begin
        r.status = fwmm_pkg::STAT_FULL;
      end else begin
        shadow_ring[ring_tail] = value;
        ring_tail = (ring_tail + 1) % RING_DEPTH;
        ring_fill++;
      end
    end else begin
      if (ring_fill == 0) begin
        r.status = fwmm_pkg::STAT_EMPTY;
      end else begin
        r.popped = shadow_ring[ring_head];
        ring_head = (ring_head + 1) % RING_DEPTH;
        ring_fill--;
      end
    end
    r.count = 6'(ring_fill);

    // Walk the held entries from the head for the extremes.
    highest = fwmm_pkg::INT_MIN;
    least = fwmm_pkg::INT_MAX;
    slot = ring_head;
    for (int n = 0; n < ring_fill; n++) begin
      if (shadow_ring[slot] > highest) highest = shadow_ring[slot];
      if (shadow_ring[slot] < least) least = shadow_ring[slot];
      slot = (slot + 1) % RING_DEPTH;
    end
    // An empty queue reports zero for both extremes.
    if (ring_fill == 0) begin
      highest = '0;
      least = '0;
    end
    r.largest = highest;
    r.lowest = least;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("time %0t: %s expected %h, got %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Results are checked before the same edge's request is recorded, so a
  // result can never be matched against its own request.
  always @(posedge clk) begin
    queue_report_t want;
    if (rst) begin
      ring_head = 0;
      ring_tail = 0;
      ring_fill = 0;
      owed_reports.delete();
      mismatch_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_reports.size() == 0) begin
          $display("time %0t: result expected none, got %h status %h",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatch_count++;
        end else begin
          want = owed_reports.pop_front();
          check_field("popped_value", want.popped, m_axis_tdata[31:0]);
          check_field("entry_count", 32'(want.count), 32'(m_axis_tdata[37:32]));
          check_field("largest_value", want.largest, m_axis_tdata[69:38]);
          check_field("smallest_value", want.lowest, m_axis_tdata[101:70]);
          check_field("tdata padding", 32'd0, 32'(m_axis_tdata[103:102]));
          check_field("status", 32'(want.status), 32'(m_axis_tuser));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        owed_reports.push_back(apply_request(s_axis_tuser, s_axis_tdata));
      end
    end
    results_owed <= owed_reports.size();
  end

endmodule

/* test/fifo_with_min_max_tb.sv */
// ----------------------------------------------------------------------------
// FIFO with min/max query: testbench top
// Drives directed and random enqueue and dequeue requests into the block,
// with random gaps on the request side and random stalls on the result
// side. A checker beside the block predicts every result and counts
// mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_with_min_max_tb;

  localparam int DEPTH = 32;
  localparam int TOTAL_REQUESTS = 1450;
  localparam int IDLE_PCT = 17;
  // Requests in this range go through with no gaps and no stalls.
  localparam int CALM_FIRST = 600;
  localparam int CALM_LAST = 900;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = fwmm_pkg::REQ_ENQ;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         calm = 1'b0;
  int           mismatch_count;
  int           results_owed;
  int           requests_sent = 0;

  fifo_with_min_max #(
    .QUEUE_DEPTH (DEPTH)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  fifo_minmax_checker #(
    .RING_DEPTH (DEPTH)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The result side stalls at random except during the calm stretch.
  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Present one request and hold it until the block takes it.
  task automatic issue_request(input logic kind, input logic [31:0] value);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= value;
    do @(posedge clk); while (!s_axis_tready);
    requests_sent++;
  endtask

  // Values lean toward the extremes and a narrow band around zero so that
  // ties and changes of the largest and smallest value come up often.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return fwmm_pkg::INT_MIN;
      1: return fwmm_pkg::INT_MAX;
      2: return 32'(int'($urandom_range(0, 200)) - 100);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int enq_pct;
    int burst_len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Dequeue on an empty queue, then the extreme values in and out again
    // until the queue is empty once more.
    issue_request(fwmm_pkg::REQ_DEQ, $urandom());
    issue_request(fwmm_pkg::REQ_ENQ, fwmm_pkg::INT_MAX);
    issue_request(fwmm_pkg::REQ_ENQ, fwmm_pkg::INT_MIN);
    issue_request(fwmm_pkg::REQ_ENQ, 32'd0);
    issue_request(fwmm_pkg::REQ_ENQ, 32'hFFFF_FFFF);
    issue_request(fwmm_pkg::REQ_ENQ, 32'd1);
    issue_request(fwmm_pkg::REQ_DEQ, fwmm_pkg::INT_MAX);
    issue_request(fwmm_pkg::REQ_DEQ, fwmm_pkg::INT_MIN);
    issue_request(fwmm_pkg::REQ_DEQ, $urandom());
    issue_request(fwmm_pkg::REQ_DEQ, $urandom());
    issue_request(fwmm_pkg::REQ_DEQ, $urandom());
    issue_request(fwmm_pkg::REQ_DEQ, $urandom());
    issue_request(fwmm_pkg::REQ_ENQ, 32'hAAAA_AAAA);
    issue_request(fwmm_pkg::REQ_ENQ, 32'h5555_5555);
    issue_request(fwmm_pkg::REQ_DEQ, $urandom());
    issue_request(fwmm_pkg::REQ_DEQ, $urandom());

    // Random bursts that mostly fill, mostly drain or mix, so the queue
    // reaches full and empty many times and the ring indices wrap.
    while (requests_sent < TOTAL_REQUESTS) begin
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 15;
        default: enq_pct = 50;
      endcase
      burst_len = $urandom_range(10, 60);
      repeat (burst_len) begin
        calm = (requests_sent >= CALM_FIRST) && (requests_sent < CALM_LAST);
        issue_request(($urandom_range(0, 99) < enq_pct) ? fwmm_pkg::REQ_ENQ
                                                        : fwmm_pkg::REQ_DEQ,
                      pick_value());
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain once the checker has counted the last request, then allow for
    // any stray result a full-queue scan could give.
    do @(posedge clk); while (results_owed != 0);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("fifo_with_min_max_tb passed");
    end else begin
      $display("fifo_with_min_max_tb failed");
    end
    $finish;
  end

  // Hang guard, well beyond the slowest correct run.
  initial begin
    #6_000_000;
    $display("fifo_with_min_max_tb failed");
    $finish;
  end

endmodule
